FILE: src/bftm_pkg.sv
`default_nettype none

package bftm_pkg;

  localparam int FRAME_COUNT = 8;
  localparam int FRAME_W = $clog2(FRAME_COUNT);

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [15:0] TEMPO_NUM = 16'd60000;
  localparam logic [31:0] GAP_MIN = 32'd100;
  localparam logic [31:0] GAP_MAX = 32'd4000;
  localparam logic [31:0] SILENCE_CLEAR = 32'd4000;
  localparam logic [15:0] SOLO_TIMEOUT_RST = 16'd1500;
  localparam logic [15:0] SOLO_INTERVAL_RST = 16'd600;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEST_MODE     = 2'd0,
    CFG_PHASE_OFFSET  = 2'd1,
    CFG_SOLO_TIMEOUT  = 2'd2,
    CFG_SOLO_INTERVAL = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_ENTER  = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic div_step;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic need_div;
    logic out_free;
  } dp_status_t;

  function automatic logic [FRAME_W-1:0] frame_wrap(input logic [2:0] v);
    int r;
    r = int'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= FRAME_COUNT) begin
        r = r - FRAME_COUNT;
      end
    end
    return FRAME_W'(r);
  endfunction

endpackage

`default_nettype wire

FILE: src/bftm_if.sv
`default_nettype none

interface bftm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] now_ms;
  logic        sync_edge;

  modport source (output valid, output operation, output now_ms, output sync_edge,
                  input ready);
  modport sink (input valid, input operation, input now_ms, input sync_edge,
                output ready);
endinterface

interface bftm_out_if;
  logic        valid;
  logic        ready;
  logic        beat;
  logic        external_beat;
  logic        frame_valid;
  logic [2:0]  frame_index;
  logic        tempo_set;
  logic [9:0]  tempo_bpm;
  logic [31:0] pulse_total;

  modport source (output valid, output beat, output external_beat, output frame_valid,
                  output frame_index, output tempo_set, output tempo_bpm,
                  output pulse_total, input ready);
  modport sink (input valid, input beat, input external_beat, input frame_valid,
                input frame_index, input tempo_set, input tempo_bpm,
                input pulse_total, output ready);
endinterface

interface bftm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/bftm_ctrl.sv
`default_nettype none

module bftm_ctrl
  import bftm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_status_t sts_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic cnt_last;

  assign cnt_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (sts_i.in_valid) begin
          state_d = sts_i.need_div ? S_DIV : S_PUSH;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.accept   = sts_i.in_valid;
      end
      S_DIV:   cmd_o.div_step = 1'b1;
      S_PUSH:  cmd_o.push = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && sts_i.need_div |=> state_q == S_DIV)
    else $error("tempo transaction did not start the divider");

  a_direct_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && !sts_i.need_div |=> state_q == S_PUSH)
    else $error("plain transaction did not go to push");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_last |=> state_q == S_PUSH)
    else $error("divider did not finish after its steps");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_free && state_q == S_PUSH)
    else $error("push into a full output register");

endmodule

`default_nettype wire

FILE: src/bftm_dp.sv
`default_nettype none

module bftm_dp
  import bftm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bftm_in_if.sink        in_i,
  bftm_out_if.source     out_o,
  bftm_cfg_if.sink       cfg_i,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     sts_o
);

  // configuration
  logic        test_mode_q;
  logic [2:0]  phase_offset_q;
  logic [15:0] solo_timeout_q;
  logic [15:0] solo_interval_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_mode_q     <= 1'b0;
      phase_offset_q  <= '0;
      solo_timeout_q  <= SOLO_TIMEOUT_RST;
      solo_interval_q <= SOLO_INTERVAL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_TEST_MODE:     test_mode_q     <= cfg_i.data[0];
        CFG_PHASE_OFFSET:  phase_offset_q  <= cfg_i.data[2:0];
        CFG_SOLO_TIMEOUT:  solo_timeout_q  <= cfg_i.data;
        CFG_SOLO_INTERVAL: solo_interval_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // tracking state
  logic [31:0]        last_beat_q, last_beat_d;
  logic [31:0]        last_ext_q, last_ext_d;
  logic [31:0]        pulse_q, pulse_d;
  logic [FRAME_W-1:0] frame_q, frame_d;

  logic p_beat_q, p_beat_d;
  logic p_ext_q, p_ext_d;
  logic p_fvalid_q, p_fvalid_d;
  logic p_tset_q, p_tset_d;
  logic p_div_q, p_div_d;

  logic [31:0] gap_beat, gap_ext;
  logic        is_enter, edge_seen, solo_beat, any_beat, gap_ok, silent;
  logic [FRAME_W-1:0] frame_inc;

  assign is_enter  = (op_e'(in_i.operation) == OP_ENTER);
  assign edge_seen = in_i.sync_edge;
  assign gap_beat  = in_i.now_ms - last_beat_q;
  assign gap_ext   = in_i.now_ms - last_ext_q;
  assign solo_beat = !test_mode_q && (gap_ext > {16'd0, solo_timeout_q})
                     && (gap_beat >= {16'd0, solo_interval_q});
  assign any_beat  = edge_seen || solo_beat;
  assign gap_ok    = (gap_beat >= GAP_MIN) && (gap_beat <= GAP_MAX);
  assign silent    = gap_beat > SILENCE_CLEAR;
  assign frame_inc = (frame_q == FRAME_W'(FRAME_COUNT - 1)) ? '0 : frame_q + 1'b1;

  assign sts_o.in_valid = in_i.valid;
  assign sts_o.need_div = !is_enter && test_mode_q && edge_seen && gap_ok;
  assign sts_o.out_free = !out_o.valid || out_o.ready;
  assign in_i.ready     = cmd_i.in_ready;

  always_comb begin
    last_beat_d = last_beat_q;
    last_ext_d  = last_ext_q;
    pulse_d     = pulse_q;
    frame_d     = frame_q;
    p_beat_d    = 1'b0;
    p_ext_d     = 1'b0;
    p_fvalid_d  = 1'b0;
    p_tset_d    = 1'b0;
    p_div_d     = 1'b0;
    if (is_enter) begin
      last_beat_d = in_i.now_ms;
      last_ext_d  = in_i.now_ms;
      pulse_d     = '0;
      if (test_mode_q) begin
        p_tset_d = 1'b1;
      end else begin
        frame_d    = frame_wrap(phase_offset_q);
        p_fvalid_d = 1'b1;
      end
    end else begin
      if (edge_seen) begin
        last_ext_d = in_i.now_ms;
        pulse_d    = pulse_q + 32'd1;
        p_ext_d    = 1'b1;
      end
      p_beat_d = any_beat;
      if (test_mode_q) begin
        if (edge_seen) begin
          p_tset_d    = gap_ok;
          p_div_d     = gap_ok;
          last_beat_d = in_i.now_ms;
        end else if (silent) begin
          p_tset_d = 1'b1;
        end
      end else if (any_beat) begin
        last_beat_d = in_i.now_ms;
        frame_d     = frame_inc;
        p_fvalid_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_beat_q <= '0;
      last_ext_q  <= '0;
      pulse_q     <= '0;
      frame_q     <= '0;
    end else if (cmd_i.accept) begin
      last_beat_q <= last_beat_d;
      last_ext_q  <= last_ext_d;
      pulse_q     <= pulse_d;
      frame_q     <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      p_beat_q   <= p_beat_d;
      p_ext_q    <= p_ext_d;
      p_fvalid_q <= p_fvalid_d;
      p_tset_q   <= p_tset_d;
      p_div_q    <= p_div_d;
    end
  end

  // restoring divider for the tempo, one quotient bit per step
  logic [12:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [11:0] dvs_q;
  logic [12:0] rem_sh;
  logic [13:0] trial;

  assign rem_sh = {rem_q[11:0], quo_q[15]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    if (trial[13]) begin
      rem_d = rem_sh;
      quo_d = {quo_q[14:0], 1'b0};
    end else begin
      rem_d = trial[12:0];
      quo_d = {quo_q[14:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rem_q <= '0;
      quo_q <= TEMPO_NUM;
      dvs_q <= gap_beat[11:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // output register
  logic               out_valid_q;
  logic               o_beat_q, o_ext_q, o_fvalid_q, o_tset_q;
  logic [2:0]         o_frame_q;
  logic [9:0]         o_bpm_q;
  logic [31:0]        o_pulse_q;
  logic [FRAME_W+2:0] frame_ext;

  assign frame_ext = {3'b000, frame_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      o_beat_q   <= p_beat_q;
      o_ext_q    <= p_ext_q;
      o_fvalid_q <= p_fvalid_q;
      o_tset_q   <= p_tset_q;
      o_frame_q  <= frame_ext[2:0];
      o_bpm_q    <= p_div_q ? quo_q[9:0] : 10'd0;
      o_pulse_q  <= pulse_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.beat          = o_beat_q;
  assign out_o.external_beat = o_ext_q;
  assign out_o.frame_valid   = o_fvalid_q;
  assign out_o.frame_index   = o_frame_q;
  assign out_o.tempo_set     = o_tset_q;
  assign out_o.tempo_bpm     = o_bpm_q;
  assign out_o.pulse_total   = o_pulse_q;

endmodule

`default_nettype wire

FILE: src/beat_follower_with_tempo_meter_top.sv
// a transaction is accepted when idle, runs the divider when a tempo is measured,
// and is pushed into the output register once it is free; only then is a new one taken
// the tempo comes from a 16-step restoring divider, one quotient bit a cycle
// the next transaction is taken while the previous result waits in the output register
// reset: asynchronous active low, clears times, pulse count, frame and the handshake state
// configuration returns to dance mode, offset 0, timeout 1500 ms, interval 600 ms
`default_nettype none

module beat_follower_with_tempo_meter_top
  import bftm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bftm_in_if.sink    in_i,
  bftm_out_if.source out_o,
  bftm_cfg_if.sink   cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  bftm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bftm_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire
